// ===== rtl/tld_pkg.sv =====
// Shared types, constants and helpers for the trajectory length block.
package tld_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int LEN_WIDTH   = 35;
    localparam int DISP_WIDTH  = 25;

    typedef logic [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          last_point;
    } point_t;

    typedef struct packed {
        logic [LEN_WIDTH-1:0]  path_length;
        logic [DISP_WIDTH-1:0] displacement;
        logic                  saturated;
    } result_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL_X,
        PH_MUL_Y,
        PH_ROOT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_DISP_GO,
        ST_DISP,
        ST_PUSH
    } state_t;

    // Flip the sign bit so that coordinates compare as unsigned.
    function automatic coord_t to_offset(input logic signed [COORD_WIDTH-1:0] v);
        return coord_t'(v) ^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
    endfunction

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
    endfunction

endpackage

// ===== rtl/tld_dist.sv =====
// Serial distance unit: floor(sqrt((dx*dx + dy*dy) << 2*FRAC_BITS)), one bit per cycle.
module tld_dist #(
    parameter  int FRAC_BITS = tld_pkg::FRAC_BITS,
    localparam int ROOT_W    = tld_pkg::COORD_WIDTH + 1 + FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tld_pkg::coord_t      dx,
    input  tld_pkg::coord_t      dy,
    output logic                 done,
    output logic [ROOT_W-1:0]    root
);

    localparam int CW    = tld_pkg::COORD_WIDTH;
    localparam int SQ_W  = 2 * CW + 1;
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int STEPS = (ROOT_W > CW) ? ROOT_W : CW;
    localparam int CNT_W = $clog2(STEPS);

    tld_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2*CW-1:0]   mcand_reg, mcand_next;
    logic [CW-1:0]     mplier_reg, mplier_next;
    logic [CW-1:0]     dy_reg, dy_next;
    logic [SQ_W-1:0]   acc_reg, acc_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              done_reg, done_next;

    logic [SQ_W-1:0]   acc_add;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    rem_diff;
    logic              take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tld_pkg::PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dy_reg     <= dy_next;
        acc_reg    <= acc_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
    end

    always_comb
    begin
        acc_add  = mplier_reg[0] ? SQ_W'(acc_reg + SQ_W'(mcand_reg)) : acc_reg;
        // remainder stays below 2^(ROOT_W+1), so its top two bits are free
        rem_sh   = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial    = REM_W'({root_reg, 2'b01});
        rem_diff = {1'b0, rem_sh} - {1'b0, trial};
        take     = !rem_diff[REM_W];

        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dy_next     = dy_reg;
        acc_next    = acc_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        done_next   = 1'b0;

        case (phase_reg)
            tld_pkg::PH_IDLE:
            begin
                if (start)
                begin
                    mcand_next  = (2*CW)'(dx);
                    mplier_next = dx;
                    dy_next     = dy;
                    acc_next    = '0;
                    cnt_next    = '0;
                    phase_next  = tld_pkg::PH_MUL_X;
                end
            end
            tld_pkg::PH_MUL_X,
            tld_pkg::PH_MUL_Y:
            begin
                acc_next    = acc_add;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(CW - 1))
                begin
                    cnt_next = '0;
                    if (phase_reg == tld_pkg::PH_MUL_X)
                    begin
                        mcand_next  = (2*CW)'(dy_reg);
                        mplier_next = dy_reg;
                        phase_next  = tld_pkg::PH_MUL_Y;
                    end
                    else
                    begin
                        rad_next   = RAD_W'(acc_add) << (2 * FRAC_BITS);
                        rem_next   = '0;
                        root_next  = '0;
                        phase_next = tld_pkg::PH_ROOT;
                    end
                end
            end
            tld_pkg::PH_ROOT:
            begin
                rem_next  = take ? rem_diff[REM_W-1:0] : rem_sh;
                root_next = {root_reg[ROOT_W-2:0], take};
                rad_next  = rad_reg << 2;
                cnt_next  = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    phase_next = tld_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = tld_pkg::PH_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/trajectory_length_and_displacement_top.sv =====
// Top level: trajectory path length and start-to-end displacement.
//
// Points of one object enter on the point channel (point_valid/point_stall),
// one request per point; a point with last_point set closes the object.
// Each closed object gives one request on the result channel
// (result_valid/result_stall): summed segment length, straight-line
// displacement and a sticky saturation flag, 8 fractional bits by default.
// Every distance goes through one shared serial unit: two shift-add
// squarings, then a square root, one root bit per cycle. The first point
// of an object is taken without a distance; every later point needs one,
// and the last point takes a second pass for the displacement before the
// result request.
// point_stall is high while a point is in the works.
// The result sits in an output register; a stalled result holds while the
// next object's points are taken, and only a later last point waits for it.
// Reset drops any object in progress and any pending result; the next point
// starts a new object.
module trajectory_length_and_displacement_top #(
    parameter int FRAC_BITS = tld_pkg::FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_stall,
    input  tld_pkg::point_t  point,
    output logic             result_valid,
    input  logic             result_stall,
    output tld_pkg::result_t result
);

    localparam int ROOT_W = tld_pkg::COORD_WIDTH + 1 + FRAC_BITS;
    localparam int LEN_W  = tld_pkg::LEN_WIDTH;
    localparam int DISP_W = tld_pkg::DISP_WIDTH;
    localparam int CMP_W  = (ROOT_W > DISP_W) ? ROOT_W : DISP_W;
    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [DISP_W-1:0] DISP_MAX = '1;

    tld_pkg::state_t  state_reg, state_next;
    tld_pkg::coord_t  start_x_reg, start_x_next;
    tld_pkg::coord_t  start_y_reg, start_y_next;
    tld_pkg::coord_t  prev_x_reg, prev_x_next;
    tld_pkg::coord_t  prev_y_reg, prev_y_next;
    logic [LEN_W-1:0] sum_reg, sum_next;
    logic             ovf_reg, ovf_next;
    logic             inside_reg, inside_next;
    logic             last_reg, last_next;
    logic [DISP_W-1:0] disp_reg, disp_next;
    logic             out_valid_reg, out_valid_next;
    tld_pkg::result_t out_reg, out_next;

    logic             accept;
    tld_pkg::coord_t  px;
    tld_pkg::coord_t  py;
    logic             dist_start;
    tld_pkg::coord_t  dist_dx;
    tld_pkg::coord_t  dist_dy;
    logic             dist_done;
    logic [ROOT_W-1:0] dist_root;
    logic [LEN_W:0]   sum_ext;
    logic [CMP_W-1:0] root_ext;
    logic             can_load;

    tld_dist #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .dx    (dist_dx),
        .dy    (dist_dy),
        .done  (dist_done),
        .root  (dist_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tld_pkg::ST_IDLE;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inside_reg    <= inside_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        sum_reg     <= sum_next;
        ovf_reg     <= ovf_next;
        last_reg    <= last_next;
        disp_reg    <= disp_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        accept   = point_valid && (state_reg == tld_pkg::ST_IDLE);
        px       = tld_pkg::to_offset(point.x);
        py       = tld_pkg::to_offset(point.y);
        sum_ext  = {1'b0, sum_reg} + (LEN_W + 1)'(dist_root);
        root_ext = CMP_W'(dist_root);
        can_load = !out_valid_reg || !result_stall;

        state_next     = state_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        inside_next    = inside_reg;
        last_next      = last_reg;
        disp_next      = disp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        dist_start     = 1'b0;
        dist_dx        = tld_pkg::abs_diff(px, prev_x_reg);
        dist_dy        = tld_pkg::abs_diff(py, prev_y_reg);

        case (state_reg)
            tld_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    prev_x_next = px;
                    prev_y_next = py;
                    last_next   = point.last_point;
                    if (!inside_reg)
                    begin
                        start_x_next = px;
                        start_y_next = py;
                        sum_next     = '0;
                        ovf_next     = 1'b0;
                        inside_next  = 1'b1;
                        if (point.last_point)
                        begin
                            state_next = tld_pkg::ST_DISP_GO;
                        end
                    end
                    else
                    begin
                        dist_start = 1'b1;
                        state_next = tld_pkg::ST_SEG;
                    end
                end
            end
            tld_pkg::ST_SEG:
            begin
                if (dist_done)
                begin
                    // saturate the running sum and keep the flag sticky
                    if (sum_ext[LEN_W])
                    begin
                        sum_next = LEN_MAX;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_ext[LEN_W-1:0];
                    end
                    state_next = last_reg ? tld_pkg::ST_DISP_GO : tld_pkg::ST_IDLE;
                end
            end
            tld_pkg::ST_DISP_GO:
            begin
                dist_dx    = tld_pkg::abs_diff(prev_x_reg, start_x_reg);
                dist_dy    = tld_pkg::abs_diff(prev_y_reg, start_y_reg);
                dist_start = 1'b1;
                state_next = tld_pkg::ST_DISP;
            end
            tld_pkg::ST_DISP:
            begin
                if (dist_done)
                begin
                    if (root_ext > CMP_W'(DISP_MAX))
                    begin
                        disp_next = DISP_MAX;
                    end
                    else
                    begin
                        disp_next = root_ext[DISP_W-1:0];
                    end
                    state_next = tld_pkg::ST_PUSH;
                end
            end
            tld_pkg::ST_PUSH:
            begin
                // hold until the output register is free
                if (can_load)
                begin
                    out_next.path_length  = sum_reg;
                    out_next.displacement = disp_reg;
                    out_next.saturated    = ovf_reg;
                    out_valid_next        = 1'b1;
                    inside_next           = 1'b0;
                    state_next            = tld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tld_pkg::ST_IDLE;
            end
        endcase
    end

    assign point_stall  = (state_reg != tld_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== bench/trajectory_length_and_displacement_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the trajectory path length and displacement block.
module trajectory_length_and_displacement_top_tb;

    // Stalls and sender gaps are short random runs.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam logic [63:0] LEN_MAX  = (64'd1 << tld_pkg::LEN_WIDTH) - 64'd1;
    localparam logic [63:0] DISP_MAX = (64'd1 << tld_pkg::DISP_WIDTH) - 64'd1;
    localparam logic signed [tld_pkg::COORD_WIDTH-1:0] COORD_MIN =
        {1'b1, {(tld_pkg::COORD_WIDTH-1){1'b0}}};
    localparam logic signed [tld_pkg::COORD_WIDTH-1:0] COORD_MAX =
        {1'b0, {(tld_pkg::COORD_WIDTH-1){1'b1}}};

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             point_valid  = 1'b0;
    logic             point_stall;
    tld_pkg::point_t  point        = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    tld_pkg::result_t result;

    // Predictor state: signed coordinates of the current object.
    int                            origin_x, origin_y, prev_x, prev_y;
    logic [tld_pkg::LEN_WIDTH-1:0] path_sum;
    logic                          path_clipped;
    logic                          in_object;

    tld_pkg::result_t pending_results[$];
    tld_pkg::result_t oldest_result;
    int      error_count   = 0;
    int      quiet_cycles  = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;

    trajectory_length_and_displacement_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // floor(sqrt((dx^2 + dy^2) * 2^(2*FRAC_BITS))), bit by bit from the top
    function automatic logic [63:0] scaled_distance(input int dx, input int dy);
        logic [63:0] squares;
        logic [63:0] root;
        logic [63:0] trial;
        squares = (64'(dx) * 64'(dx) + 64'(dy) * 64'(dy)) << (2 * tld_pkg::FRAC_BITS);
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= squares)
                root = trial;
        end
        return root;
    endfunction

    task automatic predict_point(input tld_pkg::point_t p);
        int               px;
        int               py;
        logic [63:0]      seg;
        logic [63:0]      disp;
        tld_pkg::result_t res;
        px = $signed(p.x);
        py = $signed(p.y);
        if (!in_object)
        begin
            origin_x     = px;
            origin_y     = py;
            path_sum     = '0;
            path_clipped = 1'b0;
            in_object    = 1'b1;
        end
        else
        begin
            seg = scaled_distance(magnitude(px - prev_x), magnitude(py - prev_y));
            if (seg > LEN_MAX - 64'(path_sum))
            begin
                path_sum     = LEN_MAX[tld_pkg::LEN_WIDTH-1:0];
                path_clipped = 1'b1;
            end
            else
                path_sum = path_sum + seg[tld_pkg::LEN_WIDTH-1:0];
        end
        prev_x = px;
        prev_y = py;
        if (p.last_point)
        begin
            disp = scaled_distance(magnitude(px - origin_x), magnitude(py - origin_y));
            if (disp > DISP_MAX)
                disp = DISP_MAX;
            res.path_length  = path_sum;
            res.displacement = disp[tld_pkg::DISP_WIDTH-1:0];
            res.saturated    = path_clipped;
            pending_results.push_back(res);
            in_object = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Present one point request at the falling edge and hold it until taken.
    task automatic send_point(input logic signed [tld_pkg::COORD_WIDTH-1:0] x,
                              input logic signed [tld_pkg::COORD_WIDTH-1:0] y,
                              input logic last);
        tld_pkg::point_t item;
        item.x          = x;
        item.y          = y;
        item.last_point = last;
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(negedge clk);
        end
        point_valid <= 1'b1;
        point       <= item;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        predict_point(item);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [tld_pkg::COORD_WIDTH-1:0] next_coord(
        input logic signed [tld_pkg::COORD_WIDTH-1:0] prev);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        case (pick)
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = $urandom;
            default: v = prev + int'($urandom_range(0, 600)) - 300;
        endcase
        return v[tld_pkg::COORD_WIDTH-1:0];
    endfunction

    task automatic send_object(input int n_points);
        logic signed [tld_pkg::COORD_WIDTH-1:0] x;
        logic signed [tld_pkg::COORD_WIDTH-1:0] y;
        x = (tld_pkg::COORD_WIDTH)'($urandom);
        y = (tld_pkg::COORD_WIDTH)'($urandom);
        for (int i = 0; i < n_points; i++)
        begin
            x = next_coord(x);
            y = next_coord(y);
            send_point(x, y, i == n_points - 1);
        end
    endtask

    task automatic test_single_point_objects();
        send_point(COORD_MIN, COORD_MAX, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(COORD_MAX, COORD_MIN, 1'b1);
    endtask

    task automatic test_corner_paths();
        // square around the whole plane, closing on its start
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        // widest displacement
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        // zero-length segments
        send_point(16'sd5, -16'sd7, 1'b0);
        send_point(16'sd5, -16'sd7, 1'b0);
        send_point(16'sd5, -16'sd7, 1'b1);
        // unit steps across zero
        send_point(-16'sd1, -16'sd1, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd1, 16'sd0, 1'b1);
    endtask

    task automatic test_random_objects(input int idle_pct, input int stall_level,
                                       input int n_items);
        int sent;
        int r;
        int n;
        send_idle_pct = idle_pct;
        stall_pct     = stall_level;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 6);
            else if (r < 95)
                n = $urandom_range(7, 20);
            else
                n = $urandom_range(21, 60);
            send_object(n);
            sent += n;
        end
    endtask

    // Hold off the sender until every result is out, then resume.
    task automatic test_restart_after_drain();
        @(negedge clk);
        point_valid <= 1'b0;
        wait_results_drained();
        send_object(3);
        send_object(1);
    endtask

    always @(negedge clk)
    begin
        result_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result.path_length, 0);
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result.path_length !== oldest_result.path_length)
                    report_mismatch("path_length", result.path_length,
                                    oldest_result.path_length);
                if (result.displacement !== oldest_result.displacement)
                    report_mismatch("displacement", result.displacement,
                                    oldest_result.displacement);
                if (result.saturated !== oldest_result.saturated)
                    report_mismatch("saturated", result.saturated, oldest_result.saturated);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((point_valid && !point_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("trajectory_length_and_displacement_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        in_object    = 1'b0;
        path_sum     = '0;
        path_clipped = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_point_objects();
        test_corner_paths();
        test_random_objects(0, 0, 260);
        test_random_objects(64, 0, 260);
        test_random_objects(0, 64, 260);
        test_restart_after_drain();
        test_random_objects(13, 13, 260);

        @(negedge clk);
        point_valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("trajectory_length_and_displacement_top regression: pass");
        else
            $display("trajectory_length_and_displacement_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tld_pkg.sv
rtl/tld_dist.sv
rtl/trajectory_length_and_displacement_top.sv
bench/trajectory_length_and_displacement_top_tb.sv
